### rtl/isfa_pkg.sv
package isfa_pkg;

    localparam int SAMPLE_BITS     = 12;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC_BITS  = 12;
    localparam int INTEG_FRAC_BITS = 12;
    localparam int INTEG_W         = 40;
    localparam int ERR_W           = SAMPLE_BITS + 1;
    localparam int TICK_W          = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 4;

    // Shared multiplier: gain x 25-bit signed operand, wide words fed in 24-bit halves
    localparam int MUL_B_W  = 25;
    localparam int HALF_SH  = 24;
    localparam int MUL_W    = GAIN_BITS + MUL_B_W;
    localparam int ACC_W    = 64;
    localparam int DRV_W    = 48;
    localparam int SAT_W    = ACC_W + 1;
    localparam int STEP_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BACKCALC_GAIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TICKS         = CFG_IDX_W'(3);

    localparam logic [1:0] ST_IN_RANGE = 2'd0;
    localparam logic [1:0] ST_HIGH     = 2'd1;
    localparam logic [1:0] ST_LOW      = 2'd2;

    localparam logic signed [GAIN_BITS-1:0] STATE_GAIN_RST    = 16'sd259;
    localparam logic signed [GAIN_BITS-1:0] INTEGRAL_GAIN_RST = -16'sd519;
    localparam logic signed [GAIN_BITS-1:0] BACKCALC_GAIN_RST = 16'sd3072;
    localparam logic [TICK_W-1:0]           TICKS_RST         = 16'd12;

    localparam logic signed [SAT_W-1:0] INTEG_MAX_X =
        {{(SAT_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] INTEG_MIN_X =
        {{(SAT_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] measured_sample;
        logic [SAMPLE_BITS-1:0] reference_sample;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] dac_code;
        logic [1:0]             clamp_status;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_NOP, OP_INTEG, OP_CLASSIFY, OP_BACKCALC, OP_COMMIT
    } op_t;

    typedef enum logic [1:0] {MA_SG, MA_IG, MA_BG} mul_a_t;

    typedef enum logic [2:0] {
        MB_MEAS, MB_INT_LO, MB_INT_HI, MB_EXC_LO, MB_EXC_HI
    } mul_b_t;

    typedef enum logic [1:0] {SH_NONE, SH_FRAC, SH_HALF} shift_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {DRV_HOLD, DRV_CLR, DRV_SUB} drv_op_t;
    typedef enum logic [1:0] {JMP_NEXT, JMP_IN_RANGE, JMP_END} jmp_t;

    typedef struct packed {
        op_t               op;
        mul_a_t            mul_a;
        mul_b_t            mul_b;
        shift_t            sh;
        acc_op_t           acc;
        drv_op_t           drv;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic in_range;
        logic out_free;
    } seq_in_t;

    localparam ctrl_t CW_NOP = '{op: OP_NOP, mul_a: MA_SG, mul_b: MB_MEAS, sh: SH_NONE,
                                 acc: ACC_HOLD, drv: DRV_HOLD, jmp: JMP_NEXT, target: '0};

    localparam logic [STEP_W-1:0] STEP_COMMIT = STEP_W'(12);

    function automatic ctrl_t micro_rom(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CW_NOP;
        case (step)
            STEP_W'(0):
            begin
                w.op  = OP_INTEG;
                w.drv = DRV_CLR;
            end
            STEP_W'(1):
            begin
                w.mul_a = MA_IG;
                w.mul_b = MB_INT_LO;
            end
            STEP_W'(2):
            begin
                w.mul_a = MA_IG;
                w.mul_b = MB_INT_HI;
                w.sh    = SH_HALF;
                w.acc   = ACC_LOAD;
            end
            STEP_W'(3):
            begin
                w.acc = ACC_ADD;
            end
            STEP_W'(4):
            begin
                w.mul_a = MA_SG;
                w.mul_b = MB_MEAS;
                w.sh    = SH_FRAC;
                w.drv   = DRV_SUB;
            end
            STEP_W'(5):
            begin
                w.acc = ACC_LOAD;
            end
            STEP_W'(6):
            begin
                w.drv = DRV_SUB;
            end
            STEP_W'(7):
            begin
                w.op     = OP_CLASSIFY;
                w.jmp    = JMP_IN_RANGE;
                w.target = STEP_COMMIT;
            end
            STEP_W'(8):
            begin
                w.mul_a = MA_BG;
                w.mul_b = MB_EXC_LO;
            end
            STEP_W'(9):
            begin
                w.mul_a = MA_BG;
                w.mul_b = MB_EXC_HI;
                w.sh    = SH_HALF;
                w.acc   = ACC_LOAD;
            end
            STEP_W'(10):
            begin
                w.acc = ACC_ADD;
            end
            STEP_W'(11):
            begin
                w.op = OP_BACKCALC;
            end
            STEP_COMMIT:
            begin
                w.op  = OP_COMMIT;
                w.jmp = JMP_END;
            end
            default:
            begin
                w.jmp = JMP_END;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [SAT_W-1:0] x);
        logic signed [INTEG_W-1:0] r;
        if (x > INTEG_MAX_X)
            r = INTEG_MAX_X[INTEG_W-1:0];
        else if (x < INTEG_MIN_X)
            r = INTEG_MIN_X[INTEG_W-1:0];
        else
            r = x[INTEG_W-1:0];
        return r;
    endfunction

endpackage

### rtl/integral_state_feedback_antiwindup_core.sv
// Non-sampling tick: accepted with no result; the next tick can be taken the cycle after.
// Sampling tick: the result is registered at the commit step; the back-calculation steps are
// skipped when the drive is in range. The next tick is taken once the result is registered.
// A 13-step microprogram runs all three products through one shared 16x25 multiplier.
// A pending result that is not taken holds the last step; ticks wait meanwhile.
// Reset (async, active low) loads default gains and period and clears counter and integral.
module integral_state_feedback_antiwindup_core
    import isfa_pkg::*;
#(
    parameter int GAIN_FRAC = GAIN_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  in_item_t             sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output out_item_t            result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    logic signed [GAIN_BITS-1:0] state_gain_reg, integral_gain_reg, backcalc_gain_reg;
    logic        [TICK_W-1:0]    ticks_reg;
    logic        [TICK_W-1:0]    tick_count_reg, tick_count_next;
    logic                        result_valid_reg;
    out_item_t                   result_reg;

    logic      accept, fire, busy, in_range;
    seq_in_t   sin;
    ctrl_t     cw;
    out_item_t dp_result;

    assign sample_ready    = !busy;
    assign accept          = sample_valid && sample_ready;
    assign tick_count_next = tick_count_reg + TICK_W'(1);
    assign fire            = tick_count_next == ticks_reg;

    assign sin.start    = accept && fire;
    assign sin.in_range = in_range;
    assign sin.out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    isfa_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sin   (sin),
        .cw    (cw),
        .busy  (busy)
    );

    isfa_dp #(
        .GAIN_FRAC (GAIN_FRAC)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cw            (cw),
        .start         (sin.start),
        .sample        (sample),
        .state_gain    (state_gain_reg),
        .integral_gain (integral_gain_reg),
        .backcalc_gain (backcalc_gain_reg),
        .in_range      (in_range),
        .result        (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_gain_reg    <= STATE_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            backcalc_gain_reg <= BACKCALC_GAIN_RST;
            ticks_reg         <= TICKS_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_STATE_GAIN:    state_gain_reg    <= $signed(wr_data);
                REG_INTEGRAL_GAIN: integral_gain_reg <= $signed(wr_data);
                REG_BACKCALC_GAIN: backcalc_gain_reg <= $signed(wr_data);
                REG_TICKS:         ticks_reg         <= wr_data;
                default:           ticks_reg         <= ticks_reg;
            endcase
        end
    end

    // advance the tick counter on every request; a match restarts the period
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_count_reg <= '0;
        else if (accept)
            tick_count_reg <= fire ? '0 : tick_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cw.op == OP_COMMIT)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cw.op == OP_COMMIT)
            result_reg <= dp_result;
    end

endmodule

### rtl/isfa_seq.sv
module isfa_seq
    import isfa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  seq_in_t sin,
    output ctrl_t   cw,
    output logic    busy
);

    logic              running_reg, running_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             rom_word;

    assign rom_word = micro_rom(step_reg);
    assign busy     = running_reg;

    always_comb
    begin
        cw           = CW_NOP;
        step_next    = step_reg;
        running_next = running_reg;
        if (running_reg)
        begin
            cw = rom_word;
            case (rom_word.jmp)
                JMP_NEXT:
                begin
                    step_next = step_reg + STEP_W'(1);
                end
                JMP_IN_RANGE:
                begin
                    step_next = sin.in_range ? rom_word.target : step_reg + STEP_W'(1);
                end
                JMP_END:
                begin
                    // hold on the last step until the output register is free
                    if (sin.out_free)
                    begin
                        running_next = 1'b0;
                        step_next    = '0;
                    end
                    else
                    begin
                        cw = CW_NOP;
                    end
                end
                default:
                begin
                    running_next = 1'b0;
                    step_next    = '0;
                end
            endcase
        end
        else if (sin.start)
        begin
            running_next = 1'b1;
            step_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            step_reg    <= step_next;
        end
    end

endmodule

### rtl/isfa_dp.sv
module isfa_dp
    import isfa_pkg::*;
#(
    parameter int GAIN_FRAC = GAIN_FRAC_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctrl_t                       cw,
    input  logic                        start,
    input  in_item_t                    sample,
    input  logic signed [GAIN_BITS-1:0] state_gain,
    input  logic signed [GAIN_BITS-1:0] integral_gain,
    input  logic signed [GAIN_BITS-1:0] backcalc_gain,
    output logic                        in_range,
    output out_item_t                   result
);

    localparam logic signed [DRV_W-1:0] FULL_Q =
        DRV_W'(((64'd1 << SAMPLE_BITS) - 64'd1) << INTEG_FRAC_BITS);

    logic        [SAMPLE_BITS-1:0] meas_reg, setpt_reg;
    logic signed [INTEG_W-1:0]     integ_acc_reg;
    logic signed [ERR_W-1:0]       perr_reg;
    logic signed [INTEG_W-1:0]     integ_reg;
    logic signed [ACC_W-1:0]       prod_reg, acc_reg;
    logic signed [DRV_W-1:0]       drive_reg, exc_reg;
    logic        [SAMPLE_BITS-1:0] code_reg;
    logic        [1:0]             status_reg;

    logic signed [GAIN_BITS-1:0] mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_W-1:0]     mul_full;
    logic signed [ACC_W-1:0]     mul_ext, prod_next;
    logic signed [ACC_W-1:0]     acc_sh;
    logic                        over_hi, under_lo;
    logic signed [SAT_W-1:0]     integ_sum, integ_back;
    logic signed [ERR_W-1:0]     err_next;

    always_comb
    begin
        case (cw.mul_a)
            MA_SG:   mul_a = state_gain;
            MA_IG:   mul_a = integral_gain;
            MA_BG:   mul_a = backcalc_gain;
            default: mul_a = state_gain;
        endcase
    end

    always_comb
    begin
        case (cw.mul_b)
            MB_MEAS:   mul_b = $signed({{(MUL_B_W-SAMPLE_BITS){1'b0}}, meas_reg});
            MB_INT_LO: mul_b = $signed({1'b0, integ_reg[HALF_SH-1:0]});
            MB_INT_HI: mul_b = $signed({{(MUL_B_W-INTEG_W+HALF_SH){integ_reg[INTEG_W-1]}},
                                        integ_reg[INTEG_W-1:HALF_SH]});
            MB_EXC_LO: mul_b = $signed({1'b0, exc_reg[HALF_SH-1:0]});
            MB_EXC_HI: mul_b = $signed({{(MUL_B_W-DRV_W+HALF_SH){exc_reg[DRV_W-1]}},
                                        exc_reg[DRV_W-1:HALF_SH]});
            default:   mul_b = '0;
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_ext  = ACC_W'(mul_full);

    always_comb
    begin
        case (cw.sh)
            SH_NONE: prod_next = mul_ext;
            SH_FRAC: prod_next = mul_ext <<< INTEG_FRAC_BITS;
            SH_HALF: prod_next = mul_ext <<< HALF_SH;
            default: prod_next = mul_ext;
        endcase
    end

    assign acc_sh     = acc_reg >>> GAIN_FRAC;
    assign over_hi    = drive_reg > FULL_Q;
    assign under_lo   = drive_reg[DRV_W-1];
    assign in_range   = !over_hi && !under_lo;
    assign integ_sum  = SAT_W'(integ_acc_reg) + (SAT_W'(perr_reg) <<< INTEG_FRAC_BITS);
    assign integ_back = SAT_W'(integ_reg) - SAT_W'(acc_sh);
    assign err_next   = $signed({1'b0, setpt_reg}) - $signed({1'b0, meas_reg});

    assign result.dac_code     = code_reg;
    assign result.clamp_status = status_reg;

    // controller state carried from one sampling tick to the next
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_acc_reg <= '0;
            perr_reg      <= '0;
        end
        else if (cw.op == OP_COMMIT)
        begin
            integ_acc_reg <= integ_reg;
            perr_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            meas_reg  <= sample.measured_sample;
            setpt_reg <= sample.reference_sample;
        end

        prod_reg <= prod_next;

        case (cw.acc)
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_ADD:  acc_reg <= acc_reg + prod_reg;
            default:  acc_reg <= acc_reg;
        endcase

        case (cw.drv)
            DRV_CLR: drive_reg <= '0;
            DRV_SUB: drive_reg <= drive_reg - DRV_W'(acc_sh);
            default: drive_reg <= drive_reg;
        endcase

        case (cw.op)
            OP_INTEG:
            begin
                integ_reg <= sat_integ(integ_sum);
            end
            OP_CLASSIFY:
            begin
                if (over_hi)
                begin
                    exc_reg    <= drive_reg - FULL_Q;
                    code_reg   <= '1;
                    status_reg <= ST_HIGH;
                end
                else if (under_lo)
                begin
                    exc_reg    <= drive_reg;
                    code_reg   <= '0;
                    status_reg <= ST_LOW;
                end
                else
                begin
                    exc_reg    <= drive_reg;
                    code_reg   <= drive_reg[INTEG_FRAC_BITS +: SAMPLE_BITS];
                    status_reg <= ST_IN_RANGE;
                end
            end
            OP_BACKCALC:
            begin
                integ_reg <= sat_integ(integ_back);
            end
            default:
            begin
                integ_reg <= integ_reg;
            end
        endcase
    end

endmodule
